// File: hdl/tpd_pkg.sv
// Shared types, register indexes and constants of the typed packet deframer.
`timescale 1ns / 1ps
package tpd_pkg;

   localparam int MAX_HEADER_BYTES_DEF = 8;
   localparam int LENGTH_BITS_DEF      = 16;

   localparam logic [7:0] TYPE_NIBBLE = 8'h0F;
   localparam int         BYTE_BITS   = 8'h08;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int LEN_ACC_W  = 32;

   typedef enum logic [2:0] {
      REG_TYPE_LOW_BOUND  = 3'd0,
      REG_TYPE_HIGH_BOUND = 3'd1,
      REG_ACB_TYPE_CODE   = 3'd2,
      REG_ICB_TYPE_CODE   = 3'd3,
      REG_EVENT_TYPE_CODE = 3'd4,
      REG_HEADER_TABLE_LO = 3'd5,
      REG_HEADER_TABLE_HI = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      CH_ACB   = 2'd0,
      CH_ICB   = 2'd1,
      CH_EVENT = 2'd2
   } channel_type;

   typedef struct packed {
      logic [7:0]  type_low_bound;
      logic [7:0]  type_high_bound;
      logic [7:0]  acb_type_code;
      logic [7:0]  icb_type_code;
      logic [7:0]  event_type_code;
      logic [63:0] header_table_low;
      logic [63:0] header_table_high;
   } cfg_type;

endpackage

// File: hdl/tpd_if.sv
// Request and response channel interfaces of the typed packet deframer.
`timescale 1ns / 1ps
interface tpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] channel;
   logic       first_of_packet;
   logic       last_of_packet;

   modport source (output valid, output out_byte, output channel,
                   output first_of_packet, output last_of_packet, input ready);
   modport sink   (input valid, input out_byte, input channel,
                   input first_of_packet, input last_of_packet, output ready);
endinterface

// File: hdl/tpd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module tpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // The read data holds while no read is issued.
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/tpd_csr.sv
// Configuration register bank of the typed packet deframer, written over APB.
`timescale 1ns / 1ps
module tpd_csr
   import tpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_TYPE_LOW_BOUND:  cfg_in.type_low_bound    = csr_pwdata[7:0];
            REG_TYPE_HIGH_BOUND: cfg_in.type_high_bound   = csr_pwdata[7:0];
            REG_ACB_TYPE_CODE:   cfg_in.acb_type_code     = csr_pwdata[7:0];
            REG_ICB_TYPE_CODE:   cfg_in.icb_type_code     = csr_pwdata[7:0];
            REG_EVENT_TYPE_CODE: cfg_in.event_type_code   = csr_pwdata[7:0];
            REG_HEADER_TABLE_LO: cfg_in.header_table_low  = csr_pwdata;
            REG_HEADER_TABLE_HI: cfg_in.header_table_high = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_TYPE_LOW_BOUND:  csr_prdata = {56'd0, cfg_ff.type_low_bound};
         REG_TYPE_HIGH_BOUND: csr_prdata = {56'd0, cfg_ff.type_high_bound};
         REG_ACB_TYPE_CODE:   csr_prdata = {56'd0, cfg_ff.acb_type_code};
         REG_ICB_TYPE_CODE:   csr_prdata = {56'd0, cfg_ff.icb_type_code};
         REG_EVENT_TYPE_CODE: csr_prdata = {56'd0, cfg_ff.event_type_code};
         REG_HEADER_TABLE_LO: csr_prdata = cfg_ff.header_table_low;
         REG_HEADER_TABLE_HI: csr_prdata = cfg_ff.header_table_high;
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/typed_packet_deframer.sv
// Top level of the typed packet deframer: framing sequencer around the header RAM.
`timescale 1ns / 1ps
// The deframer takes one received byte per request. A type byte strictly between the
// two configured bounds opens a packet, and its low nibble selects a descriptor of the
// header table. Type bytes and header bytes are taken at one per cycle, header bytes
// going into a small RAM with one write and one read port. When the header is complete
// the sequencer reads the little-endian length back from that RAM with one read and one
// accumulate step per length byte, checks the length, and then plays the header out
// with one RAM read and one output load per header byte. Payload bytes then pass at one
// per cycle while the response side keeps up. Requests are held off while the length
// is read and checked and the header is played out; response stalls hold play-out.
// A zero length drops the packet; a type that matches none of the three channel codes
// is consumed silently.
module typed_packet_deframer
   import tpd_pkg::*;
#(
   parameter int MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF,
   parameter int LENGTH_BITS      = LENGTH_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tpd_req_if.sink               req,
   tpd_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ADDR_W = (MAX_HEADER_BYTES > 1) ? $clog2(MAX_HEADER_BYTES) : 1;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_HEADER  = 8'b0000_0010,
      S_LEN_RD  = 8'b0000_0100,
      S_LEN_ACC = 8'b0000_1000,
      S_LEN_CHK = 8'b0001_0000,
      S_HDR_RD  = 8'b0010_0000,
      S_HDR_OUT = 8'b0100_0000,
      S_PAYLOAD = 8'b1000_0000
   } state_type;

   cfg_type cfg;

   tpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   state_type              state_ff, state_in;
   logic [7:0]             cur_type_ff, cur_type_in;
   logic [3:0]             count_ff, count_in;
   logic [3:0]             size_ff, size_in;
   logic [2:0]             off_ff, off_in;
   logic [1:0]             wm1_ff, wm1_in;
   logic [1:0]             idx_ff, idx_in;
   logic                   in_range_ff, in_range_in;
   logic [LEN_ACC_W-1:0]   len_ff, len_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [3:0]             emit_ff, emit_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic [1:0] channel_ff, channel_in;
   logic       first_ff, first_in;
   logic       last_ff, last_in;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [7:0]        ram_rdata;

   logic [3:0]  type_idx;
   logic [63:0] table_word;
   logic [7:0]  desc;
   logic [3:0]  desc_size;
   logic [3:0]  pos;
   logic [4:0]  count_next;
   logic [7:0]  len_byte;
   logic        len_sat;
   logic        ch_none;
   logic [1:0]  ch_code;
   logic        out_free;
   logic        req_fire;

   // Descriptor of the latched type, taken live from the table registers.
   assign type_idx   = 4'(cur_type_ff & TYPE_NIBBLE);
   assign table_word = type_idx[3] ? cfg.header_table_high : cfg.header_table_low;
   assign desc       = table_word[type_idx[2:0]*BYTE_BITS +: 8];

   always_comb begin
      desc_size = {1'b0, desc[2:0]} + 4'd1;
      if (32'(desc_size) > MAX_HEADER_BYTES) begin
         desc_size = 4'(MAX_HEADER_BYTES);
      end
   end

   // ACB wins over ICB, and ICB over event, when codes coincide.
   always_comb begin
      ch_none = 1'b0;
      if (cur_type_ff == cfg.acb_type_code) begin
         ch_code = CH_ACB;
      end else if (cur_type_ff == cfg.icb_type_code) begin
         ch_code = CH_ICB;
      end else if (cur_type_ff == cfg.event_type_code) begin
         ch_code = CH_EVENT;
      end else begin
         ch_code = CH_ACB;
         ch_none = 1'b1;
      end
   end

   assign pos        = {1'b0, off_ff} + {2'b00, idx_ff};
   assign count_next = {1'b0, count_ff} + 5'd1;
   assign len_byte   = in_range_ff ? ram_rdata : 8'd0;
   assign len_sat    = (LENGTH_BITS < LEN_ACC_W) && ((len_ff >> LENGTH_BITS) != '0);
   assign out_free   = !rsp_valid_ff || rsp.ready;

   always_comb begin
      unique case (state_ff)
         S_IDLE, S_HEADER: req.ready = 1'b1;
         S_PAYLOAD:        req.ready = out_free;
         default:          req.ready = 1'b0;
      endcase
   end

   assign req_fire = req.valid && req.ready;

   // Header bytes are written only while collecting and read only afterwards, so the
   // RAM never sees a write and a read of the same entry close together.
   assign ram_we    = (state_ff == S_HEADER) && req_fire && (32'(count_ff) < MAX_HEADER_BYTES);
   assign ram_waddr = count_ff[ADDR_W-1:0];
   assign ram_re    = (state_ff == S_LEN_RD) || (state_ff == S_HDR_RD);
   assign ram_raddr = (state_ff == S_LEN_RD) ? pos[ADDR_W-1:0] : emit_ff[ADDR_W-1:0];

   tpd_ram #(
      .WIDTH (8),
      .DEPTH (MAX_HEADER_BYTES)
   ) u_header_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req.rx_byte),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      cur_type_in  = cur_type_ff;
      count_in     = count_ff;
      size_in      = size_ff;
      off_in       = off_ff;
      wm1_in       = wm1_ff;
      idx_in       = idx_ff;
      in_range_in  = in_range_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_byte_in  = out_byte_ff;
      channel_in   = channel_ff;
      first_in     = first_ff;
      last_in      = last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req.rx_byte > cfg.type_low_bound)
                && (req.rx_byte < cfg.type_high_bound)) begin
               cur_type_in = req.rx_byte;
               count_in    = 4'd0;
               state_in    = S_HEADER;
            end
         end
         S_HEADER: begin
            if (req_fire) begin
               count_in = count_next[3:0];
               // A table write that shrinks the header completes it on this byte.
               if (count_next >= {1'b0, desc_size}) begin
                  count_in = 4'd0;
                  size_in  = desc_size;
                  off_in   = desc[5:3];
                  wm1_in   = desc[7:6];
                  idx_in   = 2'd0;
                  len_in   = '0;
                  state_in = S_LEN_RD;
               end
            end
         end
         S_LEN_RD: begin
            // Length bytes that lie beyond the header read as zero.
            in_range_in = pos < size_ff;
            state_in    = S_LEN_ACC;
         end
         S_LEN_ACC: begin
            len_in = len_ff | (LEN_ACC_W'(len_byte) << {idx_ff, 3'b000});
            if (idx_ff == wm1_ff) begin
               state_in = S_LEN_CHK;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = S_LEN_RD;
            end
         end
         S_LEN_CHK: begin
            if (len_ff == '0) begin
               cur_type_in = 8'd0;
               state_in    = S_IDLE;
            end else begin
               rem_in  = len_sat ? '1 : len_ff[LENGTH_BITS-1:0];
               emit_in = 4'd0;
               state_in = ch_none ? S_PAYLOAD : S_HDR_RD;
            end
         end
         S_HDR_RD: begin
            state_in = S_HDR_OUT;
         end
         S_HDR_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_byte_in  = ram_rdata;
               channel_in   = ch_code;
               first_in     = (emit_ff == 4'd0);
               last_in      = 1'b0;
               emit_in      = emit_ff + 4'd1;
               state_in     = (emit_ff + 4'd1 == size_ff) ? S_PAYLOAD : S_HDR_RD;
            end
         end
         S_PAYLOAD: begin
            if (req_fire) begin
               if (!ch_none) begin
                  rsp_valid_in = 1'b1;
                  out_byte_in  = req.rx_byte;
                  channel_in   = ch_code;
                  first_in     = 1'b0;
                  last_in      = (rem_ff <= LENGTH_BITS'(1));
               end
               if (rem_ff <= LENGTH_BITS'(1)) begin
                  rem_in      = '0;
                  cur_type_in = 8'd0;
                  state_in    = S_IDLE;
               end else begin
                  rem_in = rem_ff - LENGTH_BITS'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_type_ff  <= 8'd0;
         count_ff     <= 4'd0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_type_ff  <= cur_type_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff     <= size_in;
      off_ff      <= off_in;
      wm1_ff      <= wm1_in;
      idx_ff      <= idx_in;
      in_range_ff <= in_range_in;
      len_ff      <= len_in;
      emit_ff     <= emit_in;
      out_byte_ff <= out_byte_in;
      channel_ff  <= channel_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.out_byte        = out_byte_ff;
   assign rsp.channel         = channel_ff;
   assign rsp.first_of_packet = first_ff;
   assign rsp.last_of_packet  = last_ff;

   a_payload_has_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PAYLOAD) |-> (rem_ff != '0))
      else $error("payload phase entered with no bytes remaining");

   a_ram_write_in_header: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_HEADER))
      else $error("header RAM written outside header collection");

   a_emit_in_header: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_HDR_RD) || (state_ff == S_HDR_OUT)) |-> (emit_ff < size_ff))
      else $error("header emission index ran past the header size");

   a_payload_delivered: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (state_ff == S_PAYLOAD) && !ch_none)
         |=> (rsp.valid && !rsp.first_of_packet))
      else $error("accepted payload byte was not presented");

   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.first_of_packet && rsp.last_of_packet))
      else $error("response marked both first and last of packet");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench of the typed packet deframer: directed frames, random traffic, saturation.
`timescale 1ns / 1ps
module tb
   import tpd_pkg::*;
();

   localparam int RESET_CYCLES           = 11;
   localparam int SETTLE_CYCLES          = 32;
   localparam int WATCHDOG_LIMIT         = 2000;
   localparam int MAX_REPORTS            = 10;
   localparam int RANDOM_BYTES_PER_PHASE = 24;
   localparam int SAT_PAYLOAD_BYTES      = 8;
   localparam logic [31:0] LEN_MAX       = (32'd1 << LENGTH_BITS_DEF) - 32'd1;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_PAYLOAD
   } frame_phase_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      channel_type channel;
      logic        first_flag;
      logic        last_flag;
   } frame_byte_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tpd_req_if req ();
   tpd_rsp_if rsp ();

   typed_packet_deframer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Register copy and framing state of the predictor.
   cfg_type         csr_shadow = '0;
   frame_phase_type frame_phase = PH_IDLE;
   logic [7:0]      cur_type = 8'h00;
   logic [7:0]      hdr_store [MAX_HEADER_BYTES_DEF];
   int              hdr_count = 0;
   logic [31:0]     pay_left = 32'd0;

   frame_byte_type  expected_bytes [$];
   int              mismatches = 0;
   int              packet_bytes = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   int              quiet_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) rsp.ready <= ($urandom_range(99) >= stall_pct);

   function automatic logic [7:0] descriptor_of(input logic [7:0] t);
      logic [3:0]  idx;
      logic [63:0] word;
      idx  = 4'(t & TYPE_NIBBLE);
      word = idx[3] ? csr_shadow.header_table_high : csr_shadow.header_table_low;
      return word[8 * idx[2:0] +: 8];
   endfunction

   function automatic logic [7:0] make_desc(input int size, input int offs, input int wid);
      return {2'(wid - 1), 3'(offs), 3'(size - 1)};
   endfunction

   // Acceptance codes are matched in priority order: ACB, then ICB, then event.
   function automatic bit route_of(input logic [7:0] t, output channel_type ch);
      ch = CH_ACB;
      if (t == csr_shadow.acb_type_code) begin
         ch = CH_ACB;
      end else if (t == csr_shadow.icb_type_code) begin
         ch = CH_ICB;
      end else if (t == csr_shadow.event_type_code) begin
         ch = CH_EVENT;
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      logic [7:0]  desc;
      logic [31:0] len;
      channel_type ch;
      int          size;
      int          offs;
      int          wid;
      int          pos;
      bit          last;
      desc = descriptor_of(cur_type);
      size = int'(desc[2:0]) + 1;
      if (size > MAX_HEADER_BYTES_DEF) size = MAX_HEADER_BYTES_DEF;
      case (frame_phase)
         PH_IDLE: begin
            if (b > csr_shadow.type_low_bound && b < csr_shadow.type_high_bound) begin
               cur_type    = b;
               hdr_count   = 0;
               frame_phase = PH_HEADER;
            end
         end
         PH_HEADER: begin
            if (hdr_count < MAX_HEADER_BYTES_DEF) hdr_store[hdr_count] = b;
            hdr_count++;
            if (hdr_count >= size) begin
               offs = int'(desc[5:3]);
               wid  = int'(desc[7:6]) + 1;
               len  = 32'd0;
               // Length bytes lying beyond the header read as zero.
               for (int i = 0; i < wid; i++) begin
                  pos = offs + i;
                  if (pos < size && pos < MAX_HEADER_BYTES_DEF)
                     len |= 32'(hdr_store[pos]) << (8 * i);
               end
               if (len > LEN_MAX) len = LEN_MAX;
               hdr_count = 0;
               if (len == 32'd0) begin
                  frame_phase = PH_IDLE;
                  cur_type    = 8'h00;
               end else begin
                  pay_left    = len;
                  frame_phase = PH_PAYLOAD;
                  if (route_of(cur_type, ch)) begin
                     for (int i = 0; i < size; i++)
                        expected_bytes.push_back(frame_byte_type'{out_byte: hdr_store[i],
                           channel: ch, first_flag: (i == 0), last_flag: 1'b0});
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            last = (pay_left <= 32'd1);
            if (route_of(cur_type, ch))
               expected_bytes.push_back(frame_byte_type'{out_byte: b, channel: ch,
                  first_flag: 1'b0, last_flag: last});
            if (last) begin
               pay_left    = 32'd0;
               frame_phase = PH_IDLE;
               cur_type    = 8'h00;
            end else begin
               pay_left--;
            end
         end
         default: frame_phase = PH_IDLE;
      endcase
   endfunction

   function automatic void log_failure(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
   endfunction

   // A request and a result taken at the same edge: the request is predicted first.
   always @(posedge clock) begin
      frame_byte_type got;
      frame_byte_type want;
      if (!reset) begin
         if (req.valid && req.ready) deframe_byte(req.rx_byte);
         if (rsp.valid && rsp.ready) begin
            got.out_byte   = rsp.out_byte;
            got.channel    = channel_type'(rsp.channel);
            got.first_flag = rsp.first_of_packet;
            got.last_flag  = rsp.last_of_packet;
            if (expected_bytes.size() == 0) begin
               log_failure($sformatf("unexpected result: byte %02h ch %0d first %0b last %0b",
                  got.out_byte, got.channel, got.first_flag, got.last_flag));
            end else begin
               want = expected_bytes.pop_front();
               if (got.out_byte !== want.out_byte || got.channel !== want.channel ||
                   got.first_flag !== want.first_flag || got.last_flag !== want.last_flag)
                  log_failure($sformatf({"result mismatch: expected byte %02h ch %0d ",
                     "first %0b last %0b, got byte %02h ch %0d first %0b last %0b"},
                     want.out_byte, want.channel, want.first_flag, want.last_flag,
                     got.out_byte, got.channel, got.first_flag, got.last_flag));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("typed_packet_deframer test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.rx_byte <= b;
      do @(posedge clock); while (!req.ready);
   endtask

   // Sends a well-formed packet whose header carries the given length.
   task automatic send_packet(input logic [7:0] ptype, input logic [31:0] plen);
      logic [7:0] desc;
      logic [7:0] hdr [MAX_HEADER_BYTES_DEF];
      int         size;
      int         offs;
      int         wid;
      int         eff;
      desc = descriptor_of(ptype);
      size = int'(desc[2:0]) + 1;
      offs = int'(desc[5:3]);
      wid  = int'(desc[7:6]) + 1;
      foreach (hdr[i]) hdr[i] = 8'($urandom);
      for (int i = 0; i < wid; i++)
         if (offs + i < size) hdr[offs + i] = plen[8 * i +: 8];
      eff = (offs >= size) ? 0 : int'((plen > LEN_MAX) ? LEN_MAX : plen);
      send_byte(ptype);
      for (int i = 0; i < size; i++) send_byte(hdr[i]);
      for (int i = 0; i < eff; i++) send_byte(8'($urandom));
      packet_bytes += 1 + size + eff;
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   // A dropped or silent packet leaves no result behind, so the block may still be busy.
   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type r, input logic [63:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({r, 3'b000});
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (r)
         REG_TYPE_LOW_BOUND:  csr_shadow.type_low_bound    = v[7:0];
         REG_TYPE_HIGH_BOUND: csr_shadow.type_high_bound   = v[7:0];
         REG_ACB_TYPE_CODE:   csr_shadow.acb_type_code     = v[7:0];
         REG_ICB_TYPE_CODE:   csr_shadow.icb_type_code     = v[7:0];
         REG_EVENT_TYPE_CODE: csr_shadow.event_type_code   = v[7:0];
         REG_HEADER_TABLE_LO: csr_shadow.header_table_low  = v;
         REG_HEADER_TABLE_HI: csr_shadow.header_table_high = v;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic program_all(input cfg_type c);
      write_reg(REG_TYPE_LOW_BOUND, 64'(c.type_low_bound));
      write_reg(REG_TYPE_HIGH_BOUND, 64'(c.type_high_bound));
      write_reg(REG_ACB_TYPE_CODE, 64'(c.acb_type_code));
      write_reg(REG_ICB_TYPE_CODE, 64'(c.icb_type_code));
      write_reg(REG_EVENT_TYPE_CODE, 64'(c.event_type_code));
      write_reg(REG_HEADER_TABLE_LO, c.header_table_low);
      write_reg(REG_HEADER_TABLE_HI, c.header_table_high);
   endtask

   // Both bounds are zero after reset, so every type byte must be dropped.
   task automatic test_reset_state();
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   task automatic test_directed_frames();
      cfg_type      c;
      logic [127:0] tbl;
      settle();
      c   = '0;
      tbl = '0;
      c.type_low_bound  = 8'h10;
      c.type_high_bound = 8'hF0;
      c.acb_type_code   = 8'h20;
      c.icb_type_code   = 8'h31;
      c.event_type_code = 8'h47;
      tbl[8*0 +: 8] = make_desc(1, 0, 1);
      tbl[8*1 +: 8] = make_desc(3, 1, 2);
      tbl[8*2 +: 8] = make_desc(1, 0, 1);
      tbl[8*3 +: 8] = make_desc(1, 0, 1);
      tbl[8*4 +: 8] = make_desc(2, 2, 1);
      c.header_table_low  = tbl[63:0];
      c.header_table_high = tbl[127:64];
      program_all(c);
      send_byte(8'h10);
      send_byte(8'hF0);
      send_packet(8'h20, 32'd2);
      send_packet(8'h31, 32'd1);
      // Zero length, then a type matching no channel, then a length beyond the header.
      send_packet(8'h42, 32'd0);
      send_packet(8'h53, 32'd1);
      send_packet(8'h24, 32'd3);
   endtask

   task automatic test_equal_codes();
      cfg_type c;
      settle();
      c = csr_shadow;
      c.acb_type_code   = 8'h20;
      c.icb_type_code   = 8'h20;
      c.event_type_code = 8'h20;
      program_all(c);
      send_packet(8'h20, 32'd1);
      settle();
      c.acb_type_code = 8'h33;
      program_all(c);
      send_packet(8'h20, 32'd1);
   endtask

   task automatic test_extreme_bounds();
      cfg_type c;
      settle();
      c.type_low_bound    = 8'h00;
      c.type_high_bound   = 8'hFF;
      c.acb_type_code     = 8'h01;
      c.icb_type_code     = 8'h80;
      c.event_type_code   = 8'hFE;
      c.header_table_low  = '1;
      c.header_table_high = '1;
      program_all(c);
      send_byte(8'h00);
      send_byte(8'hFF);
      // Eight-byte header with the length in its last byte only.
      send_packet(8'hFE, 32'd1);
      settle();
      c.type_low_bound  = 8'hFF;
      c.type_high_bound = 8'h00;
      program_all(c);
      send_byte(8'h80);
      send_byte(8'h01);
   endtask

   task automatic configure_random();
      cfg_type      c;
      logic [127:0] tbl;
      int           lo;
      int           hi;
      int           size;
      int           offs;
      lo = $urandom_range(8'h30);
      hi = $urandom_range(8'hFF, 8'hD0);
      c.type_low_bound  = 8'(lo);
      c.type_high_bound = 8'(hi);
      c.acb_type_code   = 8'(($urandom_range(3) == 0) ? lo + 1 : $urandom_range(hi - 1, lo + 1));
      c.icb_type_code   = 8'($urandom_range(hi - 1, lo + 1));
      c.event_type_code = 8'(($urandom_range(3) == 0) ? hi - 1 : $urandom_range(hi - 1, lo + 1));
      for (int n = 0; n < 16; n++) begin
         size = $urandom_range(8, 1);
         offs = ($urandom_range(9) < 8) ? $urandom_range(size - 1) : $urandom_range(7);
         tbl[8 * n +: 8] = make_desc(size, offs, $urandom_range(4, 1));
      end
      c.header_table_low  = tbl[63:0];
      c.header_table_high = tbl[127:64];
      program_all(c);
   endtask

   task automatic test_random_traffic();
      int         idle_plan [4]  = '{0, 72, 0, 27};
      int         stall_plan [4] = '{0, 0, 72, 27};
      int         goal;
      int         pick;
      int         plen;
      bit         paused;
      logic [7:0] ptype;
      for (int p = 0; p < 4; p++) begin
         settle();
         configure_random();
         send_idle_pct = idle_plan[p];
         stall_pct     = stall_plan[p];
         goal          = packet_bytes + RANDOM_BYTES_PER_PHASE;
         paused        = 1'b0;
         while (packet_bytes < goal) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
               // Out-of-bounds type bytes, the bounds themselves included.
               if ($urandom_range(1))
                  send_byte(8'($urandom_range(int'(csr_shadow.type_low_bound))));
               else
                  send_byte(8'($urandom_range(255, int'(csr_shadow.type_high_bound))));
            end else begin
               pick = $urandom_range(99);
               if (pick < 25) ptype = csr_shadow.acb_type_code;
               else if (pick < 50) ptype = csr_shadow.icb_type_code;
               else if (pick < 75) ptype = csr_shadow.event_type_code;
               else ptype = 8'($urandom_range(int'(csr_shadow.type_high_bound) - 1,
                                              int'(csr_shadow.type_low_bound) + 1));
               pick = $urandom_range(99);
               if (pick < 10) plen = 0;
               else if (pick < 80) plen = $urandom_range(4, 1);
               else plen = $urandom_range(24, 5);
               send_packet(ptype, 32'(plen));
            end
            if (p == 2 && !paused && packet_bytes >= goal - RANDOM_BYTES_PER_PHASE / 2) begin
               wait_drained();
               paused = 1'b1;
            end
         end
      end
   endtask

   // A three-byte length above the 16-bit range saturates. The packet is left open after a
   // few payload bytes, none of which may carry the last flag, so this test runs last.
   task automatic test_length_saturation();
      cfg_type      c;
      logic [127:0] tbl;
      logic [31:0]  plen;
      settle();
      send_idle_pct = 0;
      stall_pct     = 0;
      tbl = '0;
      tbl[8*0 +: 8] = make_desc(4, 1, 3);
      c.type_low_bound    = 8'h10;
      c.type_high_bound   = 8'hF0;
      c.acb_type_code     = 8'h20;
      c.icb_type_code     = 8'h31;
      c.event_type_code   = 8'h42;
      c.header_table_low  = tbl[63:0];
      c.header_table_high = tbl[127:64];
      program_all(c);
      plen = 32'h0001_0005;
      send_byte(8'h20);
      send_byte(8'($urandom));
      for (int i = 0; i < 3; i++) send_byte(plen[8 * i +: 8]);
      for (int i = 0; i < SAT_PAYLOAD_BYTES; i++) send_byte(8'($urandom));
   endtask

   initial begin
      reset       <= 1'b1;
      req.valid   <= 1'b0;
      req.rx_byte <= 8'h00;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_frames();
      test_equal_codes();
      test_extreme_bounds();
      test_random_traffic();
      test_length_saturation();
      settle();
      if (mismatches == 0) begin
         $display("typed_packet_deframer test passed");
      end else begin
         $display("typed_packet_deframer test failed");
      end
      $finish;
   end

endmodule
